[src/assert_macros.svh]
// Assertion macros for the base-32 codec RTL.
// No dependencies; included by base32_id_codec.sv, the file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/b32_pkg.sv]
// Package for the base-32 id codec: constants, request kinds, digit map functions.
// No dependencies.
`default_nettype none

package b32_pkg;

   localparam int DIGITS_DEFAULT = 8;
   localparam int VALUE_BITS     = 40;
   localparam int DIGIT_BITS     = 5;
   localparam int TEXT_BYTES     = 8;
   localparam int TEXT_BITS      = 8 * TEXT_BYTES;
   localparam logic [DIGIT_BITS-1:0] DIGIT_MASK = 5'd31;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic [DIGIT_BITS-1:0] digit;
   } digit_dec_type;

   // digit value -> ASCII, alphabet 0-9 A-H J K M N P-T V-Z
   function automatic logic [7:0] enc_char(input logic [DIGIT_BITS-1:0] d);
      logic [7:0] c;
      case (d)
         5'd0:  c = "0";
         5'd1:  c = "1";
         5'd2:  c = "2";
         5'd3:  c = "3";
         5'd4:  c = "4";
         5'd5:  c = "5";
         5'd6:  c = "6";
         5'd7:  c = "7";
         5'd8:  c = "8";
         5'd9:  c = "9";
         5'd10: c = "A";
         5'd11: c = "B";
         5'd12: c = "C";
         5'd13: c = "D";
         5'd14: c = "E";
         5'd15: c = "F";
         5'd16: c = "G";
         5'd17: c = "H";
         5'd18: c = "J";
         5'd19: c = "K";
         5'd20: c = "M";
         5'd21: c = "N";
         5'd22: c = "P";
         5'd23: c = "Q";
         5'd24: c = "R";
         5'd25: c = "S";
         5'd26: c = "T";
         5'd27: c = "V";
         5'd28: c = "W";
         5'd29: c = "X";
         5'd30: c = "Y";
         5'd31: c = "Z";
         default: c = CHAR_ZERO;
      endcase
      return c;
   endfunction

   // ASCII -> digit value; valid low for anything outside the alphabet
   function automatic digit_dec_type dec_char(input logic [7:0] c);
      digit_dec_type r;
      r.valid = 1'b1;
      r.digit = '0;
      case (c)
         "0": r.digit = 5'd0;
         "1": r.digit = 5'd1;
         "2": r.digit = 5'd2;
         "3": r.digit = 5'd3;
         "4": r.digit = 5'd4;
         "5": r.digit = 5'd5;
         "6": r.digit = 5'd6;
         "7": r.digit = 5'd7;
         "8": r.digit = 5'd8;
         "9": r.digit = 5'd9;
         "A": r.digit = 5'd10;
         "B": r.digit = 5'd11;
         "C": r.digit = 5'd12;
         "D": r.digit = 5'd13;
         "E": r.digit = 5'd14;
         "F": r.digit = 5'd15;
         "G": r.digit = 5'd16;
         "H": r.digit = 5'd17;
         "J": r.digit = 5'd18;
         "K": r.digit = 5'd19;
         "M": r.digit = 5'd20;
         "N": r.digit = 5'd21;
         "P": r.digit = 5'd22;
         "Q": r.digit = 5'd23;
         "R": r.digit = 5'd24;
         "S": r.digit = 5'd25;
         "T": r.digit = 5'd26;
         "V": r.digit = 5'd27;
         "W": r.digit = 5'd28;
         "X": r.digit = 5'd29;
         "Y": r.digit = 5'd30;
         "Z": r.digit = 5'd31;
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[src/b32_core.sv]
// Combinational encode/decode datapath of the base-32 id codec.
// Depends on b32_pkg.
`default_nettype none

module b32_core #(
   parameter int DIGITS = b32_pkg::DIGITS_DEFAULT
) (
   input  wire logic                            kind,
   input  wire logic [b32_pkg::VALUE_BITS-1:0]  value_in,
   input  wire logic [b32_pkg::TEXT_BITS-1:0]   text_in,
   input  wire logic [7:0]                      text_length,
   output logic      [b32_pkg::TEXT_BITS-1:0]   text_out,
   output logic      [b32_pkg::VALUE_BITS-1:0]  value_out,
   output logic                                 ok
);
   import b32_pkg::*;

   logic [TEXT_BITS-1:0]  text_enc;
   logic [VALUE_BITS-1:0] acc;
   logic                  chars_ok;
   logic                  dec_ok;
   logic [DIGIT_BITS-1:0] enc_digit;
   logic [7:0]            dec_byte;
   digit_dec_type         dec;

   // encode: one independent digit per byte lane
   always_comb begin
      text_enc  = '0;
      enc_digit = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (i < TEXT_BYTES) begin
            enc_digit = DIGIT_BITS'(value_in >> (DIGIT_BITS * i)) & DIGIT_MASK;
            text_enc[8*i +: 8] = enc_char(enc_digit);
         end
      end
   end

   // decode: lanes beyond the text field read as '0'
   always_comb begin
      acc      = '0;
      chars_ok = 1'b1;
      dec_byte = CHAR_ZERO;
      dec      = '0;
      for (int p = 0; p < DIGITS; p++) begin
         if (p < TEXT_BYTES) begin
            dec_byte = text_in[8*p +: 8];
         end else begin
            dec_byte = CHAR_ZERO;
         end
         dec      = dec_char(dec_byte);
         chars_ok = chars_ok & dec.valid;
         if (DIGIT_BITS * p < VALUE_BITS) begin
            acc[DIGIT_BITS*p +: DIGIT_BITS] = dec.digit;
         end
      end
   end

   assign dec_ok = chars_ok && (text_length == 8'(DIGITS));

   always_comb begin
      if (kind == KIND_ENCODE) begin
         text_out  = text_enc;
         value_out = '0;
         ok        = 1'b1;
      end else begin
         text_out  = '0;
         value_out = dec_ok ? acc : '0;
         ok        = dec_ok;
      end
   end

endmodule

`default_nettype wire

[src/base32_id_codec.sv]
// Top level of the base-32 id codec: request and result registers around b32_core.
// Depends on b32_pkg, b32_core and assert_macros.svh.
//
// Usage
//   Request channel: a request (kind, value, text, length) is taken at a rising
//   edge where start is high and busy is low. busy is always low, so a request
//   may be issued in every cycle.
//   Result channel: each request yields exactly one result on rsp_text_out,
//   rsp_value_out and rsp_ok, shown for one cycle with rsp_strobe high. The
//   receiver cannot hold a result off; it must take it in that cycle.
//   Kind encode: text_out holds the 40-bit value as eight upper-case digits,
//   most significant digit in the top byte, ok = 1, value_out = 0.
//   Kind decode: a length of eight and only alphabet characters give the value
//   with ok = 1; anything else gives ok = 0 and zero fields.
// Timing
//   Order: a taken request is registered in the request stage first, then its
//   result is registered in the result stage, which drives rsp_strobe.
//   Throughput: one request per cycle; the whole digit map is a single pass of
//   table lookups between the two register stages.
// Reset
//   Synchronous, active high: clears the stage valids, so no strobe is seen
//   until a new request arrives. The payload registers are not reset.
`default_nettype none

`include "assert_macros.svh"

module base32_id_codec #(
   parameter int DIGITS = b32_pkg::DIGITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_kind,
   input  wire logic [63:0]                     req_value_in,
   input  wire logic [b32_pkg::TEXT_BITS-1:0]   req_text_in,
   input  wire logic [7:0]                      req_text_length,
   output logic                                 rsp_strobe,
   output logic      [b32_pkg::TEXT_BITS-1:0]   rsp_text_out,
   output logic      [b32_pkg::VALUE_BITS-1:0]  rsp_value_out,
   output logic                                 rsp_ok
);
   import b32_pkg::*;

   // request stage
   logic                  req_valid_ff, req_valid_in;
   logic                  kind_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [TEXT_BITS-1:0]  text_ff;
   logic [7:0]            len_ff;

   // result stage
   logic                  strobe_ff;
   logic [TEXT_BITS-1:0]  text_out_ff, text_out_in;
   logic [VALUE_BITS-1:0] value_out_ff, value_out_in;
   logic                  ok_ff, ok_in;

   // never stalls: every cycle may carry a new request
   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         strobe_ff    <= req_valid_ff;
      end
   end

   // payload: captured unconditionally, qualified by the stage valids
   always_ff @(posedge clock) begin
      kind_ff      <= req_kind;
      value_ff     <= req_value_in[VALUE_BITS-1:0];
      text_ff      <= req_text_in;
      len_ff       <= req_text_length;
      text_out_ff  <= text_out_in;
      value_out_ff <= value_out_in;
      ok_ff        <= ok_in;
   end

   b32_core #(
      .DIGITS(DIGITS)
   ) u_core (
      .kind        (kind_ff),
      .value_in    (value_ff),
      .text_in     (text_ff),
      .text_length (len_ff),
      .text_out    (text_out_in),
      .value_out   (value_out_in),
      .ok          (ok_in)
   );

   assign rsp_strobe    = strobe_ff;
   assign rsp_text_out  = text_out_ff;
   assign rsp_value_out = value_out_ff;
   assign rsp_ok        = ok_ff;

   // one strobe per registered request, in the cycle after it
   `ASSERT_NEXT(a_strobe_tracks_req, clock, reset, 1'b1,
                rsp_strobe == $past(req_valid_ff), "strobe does not follow request stage")
   // rejected decode carries all-zero fields
   `ASSERT_SAME(a_reject_zero, clock, reset, rsp_strobe && !rsp_ok,
                rsp_text_out == '0 && rsp_value_out == '0, "rejected result has nonzero fields")
   // text appears only on an encode, which is always ok with no value
   `ASSERT_SAME(a_text_is_encode, clock, reset, rsp_strobe && rsp_text_out != '0,
                rsp_ok && rsp_value_out == '0, "text out on a non-encode result")

endmodule

`default_nettype wire
